/* rtl/dsp_pkg.sv */
// dsp_pkg: types and constants of the duration string parser
// holds the transaction structs, the parser state struct and the character codes
// no dependencies
package dsp_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } dsp_in_t;

  typedef struct packed {
    logic [31:0] total_seconds;
    logic        bad_format;
  } dsp_out_t;

  typedef struct packed {
    logic [31:0] running_total;
    logic [31:0] pending_number;
    logic        error_seen;
  } dsp_state_t;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_H    = 8'h68;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_S    = 8'h73;

  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_PER_MINUTE = 32'd60;

endpackage

/* rtl/dsp_step.sv */
// dsp_step: next-state logic of the parser for one character
// combinational; digit accumulate, suffix scale-and-add, error latch
// depends on dsp_pkg
module dsp_step (
  input  dsp_pkg::dsp_state_t st,
  input  logic [7:0]          character,
  output dsp_pkg::dsp_state_t st_nxt
);
  import dsp_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] times_ten;
  logic [31:0] scaled;
  logic        is_suffix;

  assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
  assign digit     = 4'(character - CH_ZERO);
  // times ten as two shifts and an add
  assign times_ten = 32'({st.pending_number, 3'b000} + {st.pending_number, 1'b0});

  // constant multiplies, shift-add after synthesis
  always_comb begin
    scaled    = '0;
    is_suffix = 1'b1;
    unique case (character)
      CH_D:    scaled = 32'(st.pending_number * SECS_PER_DAY);
      CH_H:    scaled = 32'(st.pending_number * SECS_PER_HOUR);
      CH_M:    scaled = 32'(st.pending_number * SECS_PER_MINUTE);
      CH_S:    scaled = st.pending_number;
      default: is_suffix = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st;
    priority if (st.error_seen) begin
      st_nxt = st;
    end else if (is_digit) begin
      st_nxt.pending_number = times_ten + 32'(digit);
    end else if (is_suffix) begin
      st_nxt.running_total  = st.running_total + scaled;
      st_nxt.pending_number = '0;
    end else begin
      st_nxt.error_seen = 1'b1;
    end
  end

endmodule

/* rtl/duration_string_parser.sv */
// duration_string_parser: top level of the duration string parser
// input register, parser state and result register around dsp_step
// depends on dsp_pkg and dsp_step
//
// Parses a duration text such as 1d2h30m, one ASCII character per input
// transaction, and returns the length in seconds. Digits build a pending number;
// a lowercase d, h, m or s scales it by 86400, 3600, 60 or 1 and adds it to the
// total. Any other byte sets bad_format, the rest of the string is ignored and
// total_seconds is reported as 0. Digits with no suffix at the end are dropped.
// One result transaction leaves for each character marked last_char, and the
// parser state then returns to zero for the next string. Sums and products wrap
// modulo 2^32 without a flag. Throughput is one character per clock cycle
// while the input is not stalled: each character passes through an input
// register and is folded into the state by a constant scale and one 32-bit
// add. A last character moves on from the input register when the result
// register is free, and out_valid rises from that register; a stalled result
// only holds up the input when a further last character is waiting behind it.
module duration_string_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dsp_pkg::dsp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dsp_pkg::dsp_out_t out_data
);
  import dsp_pkg::*;

  // input register
  logic       s1_valid_r;
  dsp_in_t    s1_data_r;

  // parser state
  dsp_state_t st_r;
  dsp_state_t st_nxt;

  // result register
  logic       out_valid_r;
  dsp_out_t   out_data_r;

  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  dsp_step u_step (
    .st        (st_r),
    .character (s1_data_r.character),
    .st_nxt    (st_nxt)
  );

  // result register empty or being emptied this cycle
  assign out_free = !out_valid_r || !out_stall;
  // a last character needs room in the result register, others go straight on
  assign s1_adv   = s1_valid_r && (!s1_data_r.last_char || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // parser state: cleared after the last character of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      if (s1_data_r.last_char) begin
        st_r <= '0;
      end else begin
        st_r <= st_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_data_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_data_r.last_char) begin
      out_data_r.bad_format    <= st_nxt.error_seen;
      out_data_r.total_seconds <= st_nxt.error_seen ? '0 : st_nxt.running_total;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/dsp_checker.sv */
// dsp_checker: port-level assertions for the duration string parser
// bound to duration_string_parser at the end of this file
// depends on dsp_pkg
module dsp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input dsp_pkg::dsp_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input dsp_pkg::dsp_out_t out_data
);
  import dsp_pkg::*;

  logic in_acc;
  logic bad_char;

  assign in_acc   = in_valid && !in_stall;
  assign bad_char = !((in_data.character >= CH_ZERO) && (in_data.character <= CH_NINE)) &&
                    (in_data.character != CH_D) && (in_data.character != CH_H) &&
                    (in_data.character != CH_M) && (in_data.character != CH_S);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // bad format always reports zero seconds
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_format |-> out_data.total_seconds == '0)
    else $error("bad format with nonzero total");

  // a bad last character gives a flagged result when out_stall is low as it leaves the input register
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_char && bad_char ##1 !out_stall
    |=> out_valid && out_data.bad_format)
    else $error("bad last character not reported");

endmodule

bind duration_string_parser dsp_checker u_dsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
